FILE: rtl/core/mm4_pkg.sv
package mm4_pkg;

  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int ROW_W     = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int ACC_W     = 2 * DATA_W + $clog2(DIM);

  localparam logic [ROW_W-1:0] LAST_IDX = ROW_W'(DIM - 1);

  typedef struct packed {
    logic [1:0]               row_index;
    logic signed [DATA_W-1:0] a_col0;
    logic signed [DATA_W-1:0] a_col1;
    logic signed [DATA_W-1:0] a_col2;
    logic signed [DATA_W-1:0] a_col3;
    logic signed [DATA_W-1:0] b_col0;
    logic signed [DATA_W-1:0] b_col1;
    logic signed [DATA_W-1:0] b_col2;
    logic signed [DATA_W-1:0] b_col3;
  } in_t;

  typedef struct packed {
    logic [1:0]               out_row;
    logic signed [DATA_W-1:0] c_col0;
    logic signed [DATA_W-1:0] c_col1;
    logic signed [DATA_W-1:0] c_col2;
    logic signed [DATA_W-1:0] c_col3;
    logic                     last_row;
  } out_t;

  // sequencer to lanes and row store
  typedef struct packed {
    logic             wr_en;
    logic [ROW_W-1:0] wr_row;
    logic             issue;
    logic [ROW_W-1:0] rd_row;
    logic [ROW_W-1:0] k;
    logic             acc_en;
    logic             acc_first;
  } lane_ctl_t;

  // sequencer to merge stage
  typedef struct packed {
    logic             load;
    logic [ROW_W-1:0] row;
    logic             last;
  } emit_t;

endpackage

FILE: rtl/core/mm4_lane.sv
module mm4_lane
  import mm4_pkg::*;
(
  input  logic                     clk,
  input  lane_ctl_t                ctl,
  input  logic signed [DATA_W-1:0] b_wr,
  input  logic signed [DATA_W-1:0] a_op,
  output logic signed [DATA_W-1:0] result
);

  // this lane's column of B, one entry per row
  logic signed [DATA_W-1:0]   bcol [DIM];
  logic signed [DATA_W-1:0]   b_op;
  logic signed [2*DATA_W-1:0] prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    prod_ext;
  logic signed [ACC_W-1:0]    shifted;
  logic [ACC_W-DATA_W:0]      top_bits;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      bcol[ctl.wr_row] <= b_wr;
    end
    if (ctl.issue) begin
      b_op <= bcol[ctl.k];
    end
    prod <= a_op * b_op;
    if (ctl.acc_en) begin
      acc <= ctl.acc_first ? prod_ext : acc + prod_ext;
    end
  end

  assign prod_ext = ACC_W'(prod);

  // floor to FRAC_BITS fraction bits, then clamp to the 32-bit range
  assign shifted  = acc >>> FRAC_BITS;
  assign top_bits = shifted[ACC_W-1:DATA_W-1];

  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      result = shifted[DATA_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      result = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

endmodule

FILE: rtl/core/mm4_ctrl.sv
module mm4_ctrl
  import mm4_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] row_index,
  input  logic       slot_free,
  output logic       in_ready,
  output lane_ctl_t  ctl,
  output emit_t      emit
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]       state;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] k;
  logic             v1, f1, l1;
  logic             v2, f2, l2;
  logic             acc_done;
  logic             issue;
  logic             take;
  logic             row_ok;

  assign row_ok   = int'(row_index) < DIM;
  assign in_ready = (state == S_IDLE);
  assign take     = in_valid && in_ready;
  assign issue    = (state == S_ISSUE);

  assign ctl.wr_en     = take && row_ok;
  assign ctl.wr_row    = ROW_W'(row_index);
  assign ctl.issue     = issue;
  assign ctl.rd_row    = row;
  assign ctl.k         = k;
  assign ctl.acc_en    = v2;
  assign ctl.acc_first = f2;

  assign emit.load = (state == S_DRAIN) && acc_done && slot_free;
  assign emit.row  = row;
  assign emit.last = (row == LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      row      <= '0;
      k        <= '0;
      v1       <= 1'b0;
      f1       <= 1'b0;
      l1       <= 1'b0;
      v2       <= 1'b0;
      f2       <= 1'b0;
      l2       <= 1'b0;
      acc_done <= 1'b0;
    end else begin
      v1 <= issue;
      f1 <= issue && (k == '0);
      l1 <= issue && (k == LAST_IDX);
      v2 <= v1;
      f2 <= f1;
      l2 <= l1;
      if (v2 && l2) begin
        acc_done <= 1'b1;
      end else if (emit.load) begin
        acc_done <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take && (int'(row_index) == DIM - 1)) begin
            state <= S_ISSUE;
            row   <= '0;
            k     <= '0;
          end
        end
        S_ISSUE: begin
          k <= k + 1'b1;
          if (k == LAST_IDX) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (emit.load) begin
            if (row == LAST_IDX) begin
              state <= S_IDLE;
            end else begin
              state <= S_ISSUE;
              row   <= row + 1'b1;
              k     <= '0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/mm4_merge.sv
module mm4_merge
  import mm4_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  emit_t                    emit,
  input  logic signed [DATA_W-1:0] lane_res [DIM],
  input  logic                     out_ready,
  output logic                     slot_free,
  output logic                     out_valid,
  output out_t                     out_data
);

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_data.out_row  <= 2'(emit.row);
      out_data.c_col0   <= lane_res[0];
      out_data.c_col1   <= lane_res[1];
      out_data.c_col2   <= lane_res[2];
      out_data.c_col3   <= lane_res[3];
      out_data.last_row <= emit.last;
    end
  end

endmodule

FILE: rtl/core/matrix_multiply_4x4_unit.sv
// 4x4 signed Q16.16 matrix multiplier, C = A x B. Each input transaction
// carries row r of A and row r of B; send rows 0 to 3. Rows 0..2 are just
// stored and the block is ready again the next cycle. Row 3 starts the
// product: four lanes, one per column of C, each with one 32x32 multiplier
// and a wide accumulator, step through the four inner-product terms one per
// cycle. Each row of C passes the operand, product and accumulator registers
// and is then merged into the output register; the next row of C starts
// only once that register is free, so output stalls hold the product. Each
// element is the exact sum of the four 64-bit products, floored to 16
// fraction bits and clamped to the signed 32-bit range. Input is not taken
// while a product is being computed; the stores keep their rows afterward,
// so a later row 3 alone recomputes with the rows last written. Results
// before all four rows have ever been written are undefined.
module matrix_multiply_4x4_unit
  import mm4_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  lane_ctl_t ctl;
  emit_t     emit;
  logic      slot_free;

  // rows of A, read one element per cycle while issuing and broadcast to all lanes
  logic signed [DATA_W-1:0] a_store [DIM][DIM];
  logic signed [DATA_W-1:0] a_op;

  // incoming B row, one element per lane
  logic signed [DATA_W-1:0] b_row    [DIM];
  logic signed [DATA_W-1:0] lane_res [DIM];

  assign b_row[0] = in_data.b_col0;
  assign b_row[1] = in_data.b_col1;
  assign b_row[2] = in_data.b_col2;
  assign b_row[3] = in_data.b_col3;

  // sequencer: load transactions, then row/term stepping for the product
  mm4_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .row_index (in_data.row_index),
    .slot_free (slot_free),
    .in_ready  (in_ready),
    .ctl       (ctl),
    .emit      (emit)
  );

  // A store write on a load transaction, operand fetch on each issue step
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      a_store[ctl.wr_row][0] <= in_data.a_col0;
      a_store[ctl.wr_row][1] <= in_data.a_col1;
      a_store[ctl.wr_row][2] <= in_data.a_col2;
      a_store[ctl.wr_row][3] <= in_data.a_col3;
    end
    if (ctl.issue) begin
      a_op <= a_store[ctl.rd_row][ctl.k];
    end
  end

  // one lane per column of C; lane j keeps column j of B
  for (genvar j = 0; j < DIM; j++) begin : g_lane
    mm4_lane u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .b_wr   (b_row[j]),
      .a_op   (a_op),
      .result (lane_res[j])
    );
  end

  // gathers the lane results into one output transaction
  mm4_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .emit      (emit),
    .lane_res  (lane_res),
    .out_ready (out_ready),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: bench/matrix_multiply_4x4_unit_tb.sv
`timescale 1ns / 1ps

module matrix_multiply_4x4_unit_tb
  import mm4_pkg::*;
();

  typedef logic signed [DATA_W-1:0] q_t;
  typedef q_t quad_t [DIM];

  // a few Q16.16 values that the directed tests lean on
  localparam q_t Q_ONE     = 32'sh0001_0000;
  localparam q_t Q_MAX     = 32'sh7FFF_FFFF;
  localparam q_t Q_MIN     = 32'sh8000_0000;
  localparam q_t Q_LSB     = 32'sh0000_0001;
  localparam q_t Q_NEG_LSB = -32'sh0000_0001;

  // random run length, drain time after the last transaction and receiver hold-off
  localparam int ITEM_TARGET = 470;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES = 250;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  matrix_multiply_4x4_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // predictor state: our own copy of the A and B row stores
  // ---------------------------------------------------------------------
  q_t             a_rows [DIM][DIM];
  q_t             b_rows [DIM][DIM];
  logic [DIM-1:0] rows_written = '0;
  out_t           pending_c_rows [$];

  int errors = 0;
  int items_sent = 0;

  // idle_on gates all random gaps and stalls on both channels
  bit idle_on = 1'b1;
  // the test asks the receiver for a long hold-off through this request
  int hold_request = 0;

  // one element of C: exact sum of four 64-bit products, floored to
  // FRAC_BITS fraction bits, then clamped to 32 bits
  function automatic q_t dot_q16(int row, int col);
    logic signed [2*DATA_W-1:0] prod;
    logic signed [2*DATA_W+1:0] total;
    logic signed [2*DATA_W+1:0] floored;
    total = '0;
    for (int k = 0; k < DIM; k++) begin
      prod = a_rows[row][k] * b_rows[k][col];
      total = total + prod;
    end
    floored = total >>> FRAC_BITS;
    if (floored > 66'sd2147483647) return Q_MAX;
    if (floored < -66'sd2147483648) return Q_MIN;
    return floored[DATA_W-1:0];
  endfunction

  // store the accepted rows; row DIM-1 releases the full product
  function automatic void load_row_and_multiply(in_t item);
    int   r;
    out_t c_row;
    r = item.row_index;
    a_rows[r][0] = item.a_col0;
    a_rows[r][1] = item.a_col1;
    a_rows[r][2] = item.a_col2;
    a_rows[r][3] = item.a_col3;
    b_rows[r][0] = item.b_col0;
    b_rows[r][1] = item.b_col1;
    b_rows[r][2] = item.b_col2;
    b_rows[r][3] = item.b_col3;
    rows_written[r] = 1'b1;
    if (r == DIM - 1) begin
      for (int i = 0; i < DIM; i++) begin
        c_row.out_row  = 2'(i);
        c_row.c_col0   = dot_q16(i, 0);
        c_row.c_col1   = dot_q16(i, 1);
        c_row.c_col2   = dot_q16(i, 2);
        c_row.c_col3   = dot_q16(i, 3);
        c_row.last_row = (i == DIM - 1);
        pending_c_rows.push_back(c_row);
      end
    end
  endfunction

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // mix of full-range words, small values that stay clear of saturation,
  // and the two extremes
  function automatic q_t rand_q();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      7:          return Q_MAX;
      8:          return Q_MIN;
      default:    return $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
    endcase
  endfunction

  function automatic quad_t rand_quad();
    quad_t v;
    foreach (v[j]) v[j] = rand_q();
    return v;
  endfunction

  function automatic quad_t fill_quad(q_t x);
    quad_t v;
    foreach (v[j]) v[j] = x;
    return v;
  endfunction

  function automatic in_t make_row(int r, quad_t a, quad_t b);
    in_t item;
    item.row_index = 2'(r);
    item.a_col0 = a[0];
    item.a_col1 = a[1];
    item.a_col2 = a[2];
    item.a_col3 = a[3];
    item.b_col0 = b[0];
    item.b_col1 = b[1];
    item.b_col2 = b[2];
    item.b_col3 = b[3];
    return item;
  endfunction

  // drive one transaction and hold it until the block takes it; valid is
  // only lowered when a gap is inserted, so back-to-back items keep it high
  task automatic send_row(in_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    load_row_and_multiply(item);
    items_sent++;
  endtask

  task automatic send_random_matrix();
    for (int r = 0; r < DIM; r++) send_row(make_row(r, rand_quad(), rand_quad()));
  endtask

  task automatic send_matrix_of(q_t a_val, q_t b_val);
    for (int r = 0; r < DIM; r++) send_row(make_row(r, fill_quad(a_val), fill_quad(b_val)));
  endtask

  // sender pause: nothing more goes in until every product row is back;
  // it lowers valid first, so valid really drops before the next drive
  task automatic wait_for_products();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_c_rows.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // receiver: random stalls, plus a long hold-off counted here
  // ---------------------------------------------------------------------
  initial begin : receiver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!idle_on) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------
  // result checking against the oldest predicted row
  // ---------------------------------------------------------------------
  task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_c_rows.size() == 0) begin
        $error("product row %0d arrived with none expected", out_data.out_row);
        errors++;
      end else begin
        want = pending_c_rows.pop_front();
        check_field("out_row", 32'(want.out_row), 32'(out_data.out_row));
        check_field("c_col0", want.c_col0, out_data.c_col0);
        check_field("c_col1", want.c_col1, out_data.c_col1);
        check_field("c_col2", want.c_col2, out_data.c_col2);
        check_field("c_col3", want.c_col3, out_data.c_col3);
        check_field("last_row", 32'(want.last_row), 32'(out_data.last_row));
      end
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // A = identity, so C must come back equal to B
  task automatic test_identity();
    quad_t a;
    for (int r = 0; r < DIM; r++) begin
      a = fill_quad('0);
      a[r] = Q_ONE;
      send_row(make_row(r, a, rand_quad()));
    end
  endtask

  // both saturation directions, including min times min
  task automatic test_saturation();
    send_matrix_of(Q_MAX, Q_MAX);
    send_matrix_of(Q_MAX, Q_MIN);
    send_matrix_of(Q_MIN, Q_MIN);
  endtask

  // tiny negative products must floor toward minus infinity, not to zero
  task automatic test_floor_rounding();
    send_matrix_of(Q_NEG_LSB, Q_LSB);
  endtask

  // stores keep their rows: row 3 alone recomputes, rows may come out of order
  task automatic test_store_reuse();
    send_row(make_row(DIM - 1, rand_quad(), rand_quad()));
    send_row(make_row(2, rand_quad(), rand_quad()));
    send_row(make_row(0, rand_quad(), rand_quad()));
    send_row(make_row(DIM - 1, rand_quad(), rand_quad()));
  endtask

  // no gaps and no stalls at all for a stretch
  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (10) send_random_matrix();
    idle_on = 1'b1;
  endtask

  // receiver holds off long while the sender keeps offering matrices
  task automatic test_output_hold();
    hold_request = HOLD_CYCLES;
    repeat (3) send_random_matrix();
    wait_for_products();
  endtask

  // mostly well-formed matrices with random content, some stray or
  // reordered rows, and the odd pause until all products are back
  task automatic test_random_matrices();
    int kind;
    int r;
    while (items_sent < ITEM_TARGET) begin
      kind = $urandom_range(0, 19);
      if (kind < 15) begin
        send_random_matrix();
      end else if (kind < 18) begin
        repeat ($urandom_range(1, 3)) begin
          r = $urandom_range(0, DIM - 1);
          // never release a product that would read an unwritten row
          if (r == DIM - 1 && rows_written[DIM-2:0] != '1) r = $urandom_range(0, DIM - 2);
          send_row(make_row(r, rand_quad(), rand_quad()));
        end
      end else begin
        wait_for_products();
        send_random_matrix();
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_identity();
    test_saturation();
    test_floor_rounding();
    test_store_reuse();
    test_back_to_back();
    test_output_hold();
    test_random_matrices();

    // let the last products drain, then watch for strays
    wait_for_products();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/mm4_pkg.sv
rtl/core/mm4_lane.sv
rtl/core/mm4_ctrl.sv
rtl/core/mm4_merge.sv
rtl/core/matrix_multiply_4x4_unit.sv
bench/matrix_multiply_4x4_unit_tb.sv
